// File: rtl/core/sdg_pkg.sv
// Shared types and constants for the sidechain ducking gain core.
package sdg_pkg;

	localparam int CFG_IDX_W = 2;
	localparam int MUL_W = 18;
	localparam int PROD_W = 2 * MUL_W;

	localparam logic [15:0] FULL_GAIN = 16'h8000;

	localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AMOUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ATTACK = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 2'd3;

	typedef struct packed {
		logic        enable;
		logic [15:0] amount;
		logic [15:0] atk_coef;
		logic [15:0] rel_coef;
	} cfg_t;

endpackage

// File: rtl/core/sdg_if.sv
// Valid/ready channel interfaces for sample words and result words.
interface sdg_in_if;
	logic                 valid;
	logic                 ready;
	logic                 channel;
	logic signed [15:0]   sample;
	logic signed [15:0]   sidechain_sample;

	modport source (output valid, channel, sample, sidechain_sample, input ready);
	modport sink (input valid, channel, sample, sidechain_sample, output ready);
endinterface

interface sdg_out_if;
	logic                 valid;
	logic                 ready;
	logic                 out_channel;
	logic signed [15:0]   out_sample;
	logic [15:0]          gain;

	modport source (output valid, out_channel, out_sample, gain, input ready);
	modport sink (input valid, out_channel, out_sample, gain, output ready);
endinterface

// File: rtl/core/sdg_cfg.sv
// Configuration register bank; amount is clamped to full depth on write.
module sdg_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sdg_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [15:0]                   cfg_data,
	output sdg_pkg::cfg_t                 cfg
);

	sdg_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable <= 1'b1;
			cfg_q.amount <= '0;
			cfg_q.atk_coef <= '0;
			cfg_q.rel_coef <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				sdg_pkg::REG_ENABLE: cfg_q.enable <= cfg_data[0];
				sdg_pkg::REG_AMOUNT: begin
					cfg_q.amount <= (cfg_data > sdg_pkg::FULL_GAIN) ?
						sdg_pkg::FULL_GAIN : cfg_data;
				end
				sdg_pkg::REG_ATTACK: cfg_q.atk_coef <= cfg_data;
				sdg_pkg::REG_RELEASE: cfg_q.rel_coef <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/core/sdg_mul.sv
// Shared signed multiplier with registered product.
module sdg_mul (
	input  logic                             clk,
	input  logic signed [sdg_pkg::MUL_W-1:0]  op_a,
	input  logic signed [sdg_pkg::MUL_W-1:0]  op_b,
	output logic signed [sdg_pkg::PROD_W-1:0] prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
	end

endmodule

// File: rtl/core/sdg_seq.sv
// Sequencer and datapath: depth, smoothing and scaling through the shared multiplier.
module sdg_seq #(
	parameter int CHANNELS = 2
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sdg_pkg::cfg_t                     cfg,
	sdg_in_if.sink                            samples,
	sdg_out_if.source                         results,
	output logic signed [sdg_pkg::MUL_W-1:0]  op_a,
	output logic signed [sdg_pkg::MUL_W-1:0]  op_b,
	input  logic signed [sdg_pkg::PROD_W-1:0] prod_q
);

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic HAS_CH1 = (CHANNELS > 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DEPTH = 3'd1;
	localparam logic [2:0] S_TGT   = 3'd2;
	localparam logic [2:0] S_POLE  = 3'd3;
	localparam logic [2:0] S_GAIN  = 3'd4;
	localparam logic [2:0] S_SCALE = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	logic [2:0]          state_q;
	logic                ch_q;
	logic signed [15:0]  s_q;
	logic signed [15:0]  sc_q;
	logic                bypass_q;
	logic [15:0]         target_q;
	logic [15:0]         g_q;
	logic [15:0]         gain_q [CHANNELS];

	logic                out_valid_q;
	logic                out_ch_q;
	logic signed [15:0]  out_sample_q;
	logic [15:0]         out_gain_q;

	logic                accept;
	logic                out_load;
	logic                oor;
	logic [IDX_W-1:0]    idx;
	logic [15:0]         prev;
	logic [16:0]         sc_ext;
	logic [16:0]         mag;
	logic [15:0]         alpha;
	logic signed [17:0]  diff;
	logic [31:0]         dsum;
	logic [16:0]         depth;
	logic [16:0]         depth_c;
	logic [15:0]         target_n;
	logic signed [35:0]  acc;
	logic [16:0]         gsum;
	logic [15:0]         g_n;
	logic signed [35:0]  sp;
	logic signed [20:0]  q;
	logic signed [15:0]  sat;

	assign samples.ready = (state_q == S_IDLE);
	assign accept = samples.valid && samples.ready;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || results.ready);

	// only channel 1 can fall outside the store, and only with a single channel
	assign oor = ch_q & ~HAS_CH1;
	assign idx = oor ? '0 : IDX_W'(ch_q);
	assign prev = oor ? 16'd0 : gain_q[idx];

	assign sc_ext = {sc_q[15], sc_q};
	assign mag = sc_q[15] ? 17'(-sc_ext) : sc_ext;
	assign alpha = (target_q > prev) ? cfg.atk_coef : cfg.rel_coef;
	assign diff = $signed({2'b00, prev}) - $signed({2'b00, target_q});

	// depth = round(|sc| * amount / 2^15), target = 1 - depth
	assign dsum = prod_q[31:0] + 32'd16384;
	assign depth = dsum[31:15];
	assign depth_c = (depth > {1'b0, sdg_pkg::FULL_GAIN}) ? {1'b0, sdg_pkg::FULL_GAIN} : depth;
	assign target_n = 16'({1'b0, sdg_pkg::FULL_GAIN} - depth_c);

	// (1-a)*t + a*p rewritten as t*2^16 + a*(p-t)
	assign acc = $signed({4'b0000, target_q, 16'h0000}) + prod_q + 36'sd32768;
	assign gsum = acc[32:16];
	assign g_n = (gsum > {1'b0, sdg_pkg::FULL_GAIN}) ? sdg_pkg::FULL_GAIN : gsum[15:0];

	assign sp = prod_q + 36'sd16384;
	assign q = sp[35:15];
	always_comb begin
		if (q > 21'sd32767) begin
			sat = 16'sh7FFF;
		end else if (q < -21'sd32768) begin
			sat = 16'sh8000;
		end else begin
			sat = q[15:0];
		end
	end

	always_comb begin
		case (state_q)
			S_DEPTH: begin
				op_a = $signed({1'b0, mag});
				op_b = $signed({2'b00, cfg.amount});
			end
			S_POLE: begin
				op_a = $signed({2'b00, alpha});
				op_b = diff;
			end
			// operands held through completion so the product survives a stalled result
			S_SCALE, S_DONE: begin
				op_a = $signed({{2{s_q[15]}}, s_q});
				op_b = $signed({2'b00, g_q});
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE:  if (accept) state_q <= S_DEPTH;
				S_DEPTH: state_q <= S_TGT;
				S_TGT:   state_q <= S_POLE;
				S_POLE:  state_q <= S_GAIN;
				S_GAIN:  state_q <= S_SCALE;
				S_SCALE: state_q <= S_DONE;
				S_DONE:  if (out_load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q <= samples.channel;
			s_q <= samples.sample;
			sc_q <= samples.sidechain_sample;
			bypass_q <= ~cfg.enable;
		end
		if (state_q == S_TGT) target_q <= target_n;
		if (state_q == S_GAIN) g_q <= g_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) gain_q[i] <= '0;
		end else if (out_load && !bypass_q && !oor) begin
			gain_q[idx] <= g_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_ch_q <= ch_q;
			if (oor) begin
				out_sample_q <= s_q;
				out_gain_q <= '0;
			end else if (bypass_q) begin
				out_sample_q <= s_q;
				out_gain_q <= prev;
			end else begin
				out_sample_q <= sat;
				out_gain_q <= g_q;
			end
		end
	end

	assign results.valid = out_valid_q;
	assign results.out_channel = out_ch_q;
	assign results.out_sample = out_sample_q;
	assign results.gain = out_gain_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_DEPTH)
		else $error("accepted word did not start the sequence");

	a_gain_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCALE |-> g_q <= sdg_pkg::FULL_GAIN)
		else $error("smoothed gain above unity");

	a_store_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_DONE |=> $stable(gain_q[0]))
		else $error("gain store written outside completion");

	a_out_gain_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_gain_q <= sdg_pkg::FULL_GAIN)
		else $error("result gain above unity");

endmodule

// File: rtl/core/sidechain_ducking_gain_core.sv
// Top level of the sidechain ducking gain core.
//
//   channel   dir  kind        payload
//   samples   in   valid/rdy   channel, sample, sidechain_sample
//   results   out  valid/rdy   out_channel, out_sample, gain
//   cfg_*     in   write only  cfg_idx, cfg_data (enable, amount, attack, release)
//
// A word runs from acceptance to the result register as three passes through
// the one 18x18 multiplier (depth, smoothing, scaling) with a register step
// between each. Input is ready again from the edge that loads the result, so
// a new word is not taken while the last is still in the sequencer.
// A stalled result holds the sequencer at completion until it is taken.
// Reset clears the per-channel gains to zero and sets enable.
module sidechain_ducking_gain_core #(
	parameter int CHANNELS = 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [sdg_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [15:0]                   cfg_data,
	sdg_in_if.sink                        samples,
	sdg_out_if.source                     results
);

	sdg_pkg::cfg_t                      cfg;
	logic signed [sdg_pkg::MUL_W-1:0]   op_a;
	logic signed [sdg_pkg::MUL_W-1:0]   op_b;
	logic signed [sdg_pkg::PROD_W-1:0]  prod_q;

	sdg_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	sdg_mul u_mul (
		.clk    (clk),
		.op_a   (op_a),
		.op_b   (op_b),
		.prod_q (prod_q)
	);

	sdg_seq #(
		.CHANNELS (CHANNELS)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.samples (samples),
		.results (results),
		.op_a    (op_a),
		.op_b    (op_b),
		.prod_q  (prod_q)
	);

endmodule
